// File: hw/rtl/fhm_pkg.sv
// ----------------------------------------------------------------------------
// fhm_pkg
// Shared types and codes for the mutex with a first-in first-out wait queue.
// ----------------------------------------------------------------------------
package fhm_pkg;

  // Operation codes carried in req_type.
  localparam logic [1:0] REQ_LOCK    = 2'd0;
  localparam logic [1:0] REQ_TRYLOCK = 2'd1;
  localparam logic [1:0] REQ_UNLOCK  = 2'd2;

  // Result status codes.
  localparam logic [2:0] ST_GRANTED  = 3'd0;
  localparam logic [2:0] ST_QUEUED   = 3'd1;
  localparam logic [2:0] ST_BUSY     = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_RELEASED = 3'd4;
  localparam logic [2:0] ST_HANDOFF  = 3'd5;

  // Input transaction payload.
  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] requester_id;
  } req_t;

  // Output transaction payload.
  typedef struct packed {
    logic [2:0] status;
    logic       wake_valid;
    logic [7:0] wake_thread;
    logic       owner_valid;
    logic [7:0] owner_id;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic ld_req;
    logic exec;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_full;
  } sts_t;

endpackage

// File: hw/rtl/fifo_handoff_mutex.sv
// ----------------------------------------------------------------------------
// fifo_handoff_mutex
// Hardware mutex with a first-in first-out wait queue and direct handoff.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the in channel (valid/ready) as req_type and
//   requester_id: lock, trylock or unlock. Each request produces exactly one
//   result transaction on the out channel (valid/ready) with the status,
//   an optional wake of the thread handed ownership, and the owner after
//   the request.
//   Result: an accepted request is latched, then executes once the result
//   register is free or drained in that cycle; the result is registered.
//   One request at a time: the block takes a request,
//   then executes it against the owner register and one end of the wait
//   queue; the next request is taken in the cycle after execution.
//   The head of the queue memory is read continuously into a register, so
//   an unlock with waiters does not wait for a memory read.
//   Stalls: the result sits in an output register. A new request may be
//   accepted while it waits; that request executes once the register is
//   taken or drained in the same cycle.
//   Reset: the mutex is free, the queue is empty and no result is pending.
//   Queue memory contents are not cleared; only written entries are read.
// ----------------------------------------------------------------------------
module fifo_handoff_mutex #(
  parameter int MAX_WAITERS    = 16,
  parameter int THREAD_ID_BITS = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  fhm_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output fhm_pkg::rsp_t out_data_o
);

  fhm_pkg::cmd_t cmd;
  fhm_pkg::sts_t sts;

  // Controller.
  fhm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath.
  fhm_dpath #(
    .MAX_WAITERS    (MAX_WAITERS),
    .THREAD_ID_BITS (THREAD_ID_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

// File: hw/rtl/fhm_ctrl.sv
// ----------------------------------------------------------------------------
// fhm_ctrl
// Sequencer: takes one request, then executes it once the result register
// has room.
// ----------------------------------------------------------------------------
module fhm_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          out_ready_i,
  input  fhm_pkg::sts_t sts_i,
  output fhm_pkg::cmd_t cmd_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_q, state_d;
  logic exec_ok;

  // The result register can take a new result when empty or being drained.
  assign exec_ok = !sts_i.out_full || out_ready_i;

  // Next-state and command decode.
  always_comb begin
    state_d      = state_q;
    in_ready_o   = 1'b0;
    cmd_o.ld_req = 1'b0;
    cmd_o.exec   = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.ld_req = 1'b1;
          state_d      = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_ok) begin
          cmd_o.exec = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: hw/rtl/fhm_dpath.sv
// ----------------------------------------------------------------------------
// fhm_dpath
// Owner register, wait queue memory with head and tail pointers, and the
// result register.
// ----------------------------------------------------------------------------
module fhm_dpath #(
  parameter int MAX_WAITERS    = 16,
  parameter int THREAD_ID_BITS = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  fhm_pkg::req_t in_data_i,
  input  logic          out_ready_i,
  output logic          out_valid_o,
  output fhm_pkg::rsp_t out_data_o,
  input  fhm_pkg::cmd_t cmd_i,
  output fhm_pkg::sts_t sts_o
);

  localparam int PTR_W = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
  localparam int CNT_W = $clog2(MAX_WAITERS + 1);
  localparam int TID_W = THREAD_ID_BITS;
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(MAX_WAITERS - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(MAX_WAITERS);

  fhm_pkg::req_t     req_q;
  logic              held_q, held_d;
  logic [TID_W-1:0]  owner_q, owner_d;
  logic [PTR_W-1:0]  head_q, head_d, tail_q, tail_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [TID_W-1:0]  mem [MAX_WAITERS];
  logic [TID_W-1:0]  head_data_q;
  logic              push;
  logic [TID_W-1:0]  who;
  logic [15:0]       who_wide;
  logic [15:0]       owner_wide;
  logic [15:0]       wake_wide;
  logic [2:0]        status;
  logic              wake;
  logic              out_valid_q;
  fhm_pkg::rsp_t     out_q;

  // Latch the accepted request.
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_req) begin
      req_q <= in_data_i;
    end
  end

  assign who_wide = {8'd0, req_q.requester_id};
  assign who      = who_wide[TID_W-1:0];

  // Operation decode and next state.
  always_comb begin
    held_d  = held_q;
    owner_d = owner_q;
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    push    = 1'b0;
    wake    = 1'b0;
    status  = fhm_pkg::ST_BUSY;
    case (req_q.req_type)
      fhm_pkg::REQ_LOCK: begin
        if (!held_q) begin
          held_d  = 1'b1;
          owner_d = who;
          status  = fhm_pkg::ST_GRANTED;
        end else if (count_q >= FULL_CNT) begin
          status = fhm_pkg::ST_FULL;
        end else begin
          push    = 1'b1;
          tail_d  = (tail_q == LAST_SLOT) ? '0 : tail_q + 1'b1;
          count_d = count_q + 1'b1;
          status  = fhm_pkg::ST_QUEUED;
        end
      end
      fhm_pkg::REQ_TRYLOCK: begin
        if (!held_q) begin
          held_d  = 1'b1;
          owner_d = who;
          status  = fhm_pkg::ST_GRANTED;
        end
      end
      fhm_pkg::REQ_UNLOCK: begin
        if (count_q == '0) begin
          held_d  = 1'b0;
          owner_d = '0;
          status  = fhm_pkg::ST_RELEASED;
        end else begin
          head_d  = (head_q == LAST_SLOT) ? '0 : head_q + 1'b1;
          count_d = count_q - 1'b1;
          held_d  = 1'b1;
          owner_d = head_data_q;
          wake    = 1'b1;
          status  = fhm_pkg::ST_HANDOFF;
        end
      end
      default: status = fhm_pkg::ST_BUSY;
    endcase
  end

  // Mutex state registers, updated only when a request executes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q  <= 1'b0;
      owner_q <= '0;
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else if (cmd_i.exec) begin
      held_q  <= held_d;
      owner_q <= owner_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  // Wait queue memory. The head entry is read every cycle, so the
  // registered read data is current by the time a request executes.
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && push) begin
      mem[tail_q] <= who;
    end
    head_data_q <= mem[head_q];
  end

  assign owner_wide = 16'(owner_d);
  assign wake_wide  = 16'(head_data_q);

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.exec) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      out_q.status      <= status;
      out_q.wake_valid  <= wake;
      out_q.wake_thread <= wake ? wake_wide[7:0] : 8'd0;
      out_q.owner_valid <= held_d;
      out_q.owner_id    <= held_d ? owner_wide[7:0] : 8'd0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_data_o   = out_q;
  assign sts_o.out_full = out_valid_q;

endmodule

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the mutex with a first-in first-out wait queue.
// A scoreboard class keeps its own copy of the owner, the wait queue and the
// queue pointers. It predicts one result for every accepted request and
// compares each returned result field by field, in order. The stimulus
// starts with a short directed sequence. Random bursts of contention, drains
// and mixed traffic follow, under three idle profiles and one long
// back-pressure stretch on the result channel.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int          QUEUE_DEPTH   = 16;
  localparam int          ITEM_TARGET   = 1750;
  localparam int          CYCLE_LIMIT   = 300000;
  localparam int          DRAIN_CYCLES  = 10;
  localparam int          HOLD_CYCLES   = 300;
  localparam int          PRINT_LIMIT   = 50;
  localparam logic [1:0]  REQ_RESERVED  = 2'd3;

  // Kinds of random request bursts.
  typedef enum int {
    BURST_CONTEND,
    BURST_DRAIN,
    BURST_MIXED,
    BURST_NOISE
  } burst_e;

  // Scoreboard: mutex predictor plus the queue of predicted results.
  class mutex_scoreboard;
    logic                      held;
    logic [7:0]                owner;
    logic [7:0]                waiters [QUEUE_DEPTH];
    int unsigned               head;
    int unsigned               tail;
    int unsigned               count;
    fhm_pkg::rsp_t             pending [$];
    int                        errors;

    function new();
      held   = 1'b0;
      owner  = '0;
      head   = 0;
      tail   = 0;
      count  = 0;
      errors = 0;
    endfunction

    // Apply one accepted request to the predicted state and queue its result.
    function void note_request(fhm_pkg::req_t req);
      fhm_pkg::rsp_t exp_rsp;
      exp_rsp        = '0;
      exp_rsp.status = fhm_pkg::ST_BUSY;
      case (req.req_type)
        fhm_pkg::REQ_LOCK: begin
          if (!held) begin
            held           = 1'b1;
            owner          = req.requester_id;
            exp_rsp.status = fhm_pkg::ST_GRANTED;
          end else if (count >= QUEUE_DEPTH) begin
            exp_rsp.status = fhm_pkg::ST_FULL;
          end else begin
            waiters[tail]  = req.requester_id;
            tail           = (tail + 1) % QUEUE_DEPTH;
            count++;
            exp_rsp.status = fhm_pkg::ST_QUEUED;
          end
        end
        fhm_pkg::REQ_TRYLOCK: begin
          if (!held) begin
            held           = 1'b1;
            owner          = req.requester_id;
            exp_rsp.status = fhm_pkg::ST_GRANTED;
          end
        end
        fhm_pkg::REQ_UNLOCK: begin
          if (count == 0) begin
            held           = 1'b0;
            owner          = '0;
            exp_rsp.status = fhm_pkg::ST_RELEASED;
          end else begin
            owner               = waiters[head];
            head                = (head + 1) % QUEUE_DEPTH;
            count--;
            held                = 1'b1;
            exp_rsp.wake_valid  = 1'b1;
            exp_rsp.wake_thread = owner;
            exp_rsp.status      = fhm_pkg::ST_HANDOFF;
          end
        end
        default: ;
      endcase
      exp_rsp.owner_valid = held;
      exp_rsp.owner_id    = held ? owner : '0;
      pending.push_back(exp_rsp);
    endfunction

    // Print one mismatch line, up to a cap, and count it.
    task report_mismatch(string msg);
      if (errors < PRINT_LIMIT) $display("MISMATCH: %s", msg);
      errors++;
    endtask

    // Compare one returned result with the oldest prediction.
    task check_result(fhm_pkg::rsp_t got);
      fhm_pkg::rsp_t exp_rsp;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", got));
      end else begin
        exp_rsp = pending.pop_front();
        if (got.status !== exp_rsp.status)
          report_mismatch($sformatf("status got %0d want %0d",
                                    got.status, exp_rsp.status));
        if (got.wake_valid !== exp_rsp.wake_valid)
          report_mismatch($sformatf("wake_valid got %b want %b",
                                    got.wake_valid, exp_rsp.wake_valid));
        if (got.wake_thread !== exp_rsp.wake_thread)
          report_mismatch($sformatf("wake_thread got %h want %h",
                                    got.wake_thread, exp_rsp.wake_thread));
        if (got.owner_valid !== exp_rsp.owner_valid)
          report_mismatch($sformatf("owner_valid got %b want %b",
                                    got.owner_valid, exp_rsp.owner_valid));
        if (got.owner_id !== exp_rsp.owner_id)
          report_mismatch($sformatf("owner_id got %h want %h",
                                    got.owner_id, exp_rsp.owner_id));
      end
    endtask
  endclass

  logic           clk_i       = 1'b0;
  logic           rst_ni      = 1'b0;
  logic           in_valid_i  = 1'b0;
  logic           in_ready_o;
  fhm_pkg::req_t  in_data_i   = '0;
  logic           out_valid_o;
  logic           out_ready_i = 1'b0;
  fhm_pkg::rsp_t  out_data_o;

  mutex_scoreboard mutex_sb;
  int              tx_idle_pct  = 0;
  int              rx_idle_pct  = 0;
  int              items_sent   = 0;
  int              stall_ask    = 0;
  int              stall_seen   = 0;
  int              hold_left    = 0;
  int              cycle_count  = 0;

  fifo_handoff_mutex DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // Free-running clock.
  always #5 clk_i = ~clk_i;

  // Run limit in case the block hangs.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Result side: check each transaction, then pick the next ready value.
  // A requested hold-off keeps ready low for a long stretch.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) mutex_sb.check_result(out_data_o);
      if (stall_seen != stall_ask) begin
        stall_seen = stall_ask;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Offer one request, with an optional idle gap first, and wait for it to
  // be taken. Called at a rising edge; returns at the accepting edge.
  task automatic send_request(input logic [1:0] op, input logic [7:0] id);
    fhm_pkg::req_t req;
    req.req_type     = op;
    req.requester_id = id;
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (!in_ready_o);
    mutex_sb.note_request(req);
    items_sent++;
  endtask

  // Random bursts until the item count reaches the given mark.
  task automatic run_random(input int mark);
    burst_e      kind;
    int          len;
    int          pick;
    logic [1:0]  op;
    while (items_sent < mark) begin
      pick = $urandom_range(99);
      if (pick < 35)      kind = BURST_CONTEND;
      else if (pick < 70) kind = BURST_DRAIN;
      else if (pick < 90) kind = BURST_MIXED;
      else                kind = BURST_NOISE;
      len = $urandom_range(1, 20);
      for (int i = 0; i < len; i++) begin
        case (kind)
          BURST_CONTEND:
            op = ($urandom_range(9) < 8) ? fhm_pkg::REQ_LOCK : fhm_pkg::REQ_TRYLOCK;
          BURST_DRAIN:
            op = ($urandom_range(9) < 9) ? fhm_pkg::REQ_UNLOCK : fhm_pkg::REQ_TRYLOCK;
          BURST_MIXED:
            op = 2'($urandom_range(3));
          default:
            op = ($urandom_range(1) == 0) ? REQ_RESERVED : fhm_pkg::REQ_TRYLOCK;
        endcase
        send_request(op, 8'($urandom_range(255)));
      end
    end
  endtask

  // Main sequence: reset, directed cases, three random phases, then drain.
  initial begin
    mutex_sb    = new();
    tx_idle_pct = 15;
    rx_idle_pct = 82;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Unlock and a reserved code on a free mutex.
    send_request(fhm_pkg::REQ_UNLOCK,  8'hff);
    send_request(REQ_RESERVED,         8'h00);
    // Trylock grants, then reports busy to another thread.
    send_request(fhm_pkg::REQ_TRYLOCK, 8'hff);
    send_request(fhm_pkg::REQ_TRYLOCK, 8'h00);
    // The owner queues behind itself, then another thread queues.
    send_request(fhm_pkg::REQ_LOCK,    8'hff);
    send_request(fhm_pkg::REQ_LOCK,    8'h00);
    send_request(REQ_RESERVED,         8'hff);
    // Unlocks by a non-owner hand off in order, then free the mutex.
    send_request(fhm_pkg::REQ_UNLOCK,  8'h5a);
    send_request(fhm_pkg::REQ_UNLOCK,  8'ha5);
    send_request(fhm_pkg::REQ_UNLOCK,  8'h00);
    // Lock on a free mutex, then release.
    send_request(fhm_pkg::REQ_LOCK,    8'ha5);
    send_request(fhm_pkg::REQ_UNLOCK,  8'ha5);

    run_random(ITEM_TARGET / 3);
    tx_idle_pct = 82;
    rx_idle_pct = 15;
    run_random((2 * ITEM_TARGET) / 3);

    // No idling; the result side first holds off so the block backs up.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    stall_ask++;
    run_random(ITEM_TARGET);
    in_valid_i <= 1'b0;

    while (mutex_sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mutex_sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
